// ===== rtl/aoq_pkg.sv =====
package aoq_pkg;

    localparam int DEPTH      = 16;
    localparam int STAMP_BITS = 16;
    localparam int FIELD_W    = 16;

    typedef logic [STAMP_BITS-1:0] stamp_t;
    typedef logic [FIELD_W-1:0]    field_t;

    typedef enum logic [1:0] {
        CMD_ENQ,
        CMD_DEQ_ANY,
        CMD_DEQ_CLASS,
        CMD_REMOVE
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_POP,
        OP_REMOVE
    } row_op_t;

    typedef struct packed {
        row_op_t op;
        stamp_t  load_stamp;
        stamp_t  want;
    } row_ctrl_t;

    typedef struct packed {
        logic   head_valid;
        stamp_t head_stamp;
        logic   full;
        logic   found;
    } row_stat_t;

    function automatic field_t stamp_to_field(input stamp_t s);
        logic [STAMP_BITS+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, s};
        return w[FIELD_W-1:0];
    endfunction

    function automatic stamp_t field_to_stamp(input field_t f);
        logic [STAMP_BITS+FIELD_W-1:0] w;
        w = {{STAMP_BITS{1'b0}}, f};
        return w[STAMP_BITS-1:0];
    endfunction

endpackage

// ===== rtl/aoq_cell.sv =====
module aoq_cell
    import aoq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  row_ctrl_t ctrl,
    input  logic      prev_valid,
    input  logic      nxt_valid,
    input  stamp_t    nxt_stamp,
    input  logic      hit_in,
    output logic      valid,
    output stamp_t    stamp,
    output logic      hit_out
);

    logic   valid_reg;
    logic   valid_next;
    stamp_t stamp_reg;
    stamp_t stamp_next;
    logic   load;
    logic   shift;

    assign hit_out = hit_in || (valid_reg && (stamp_reg == ctrl.want));
    assign load    = (ctrl.op == OP_LOAD) && !valid_reg && prev_valid;
    assign shift   = (ctrl.op == OP_POP) || ((ctrl.op == OP_REMOVE) && hit_out);

    always_comb
    begin
        valid_next = valid_reg;
        stamp_next = stamp_reg;
        if (load)
        begin
            valid_next = 1'b1;
            stamp_next = ctrl.load_stamp;
        end
        else if (shift)
        begin
            // advance the neighbor's entry into this cell
            valid_next = nxt_valid;
            stamp_next = nxt_stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
    end

    assign valid = valid_reg;
    assign stamp = stamp_reg;

endmodule

// ===== rtl/aoq_row.sv =====
module aoq_row
    import aoq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  row_ctrl_t ctrl,
    output row_stat_t stat
);

    logic   valid [DEPTH];
    stamp_t stamp [DEPTH];
    logic   hit   [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic   prev_v;
        logic   nxt_v;
        stamp_t nxt_s;
        logic   hit_i;

        if (i == 0)
        begin : g_head
            assign prev_v = 1'b1;
            assign hit_i  = 1'b0;
        end
        else
        begin : g_body
            assign prev_v = valid[i-1];
            assign hit_i  = hit[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign nxt_v = 1'b0;
            assign nxt_s = '0;
        end
        else
        begin : g_inner
            assign nxt_v = valid[i+1];
            assign nxt_s = stamp[i+1];
        end

        aoq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_valid (prev_v),
            .nxt_valid  (nxt_v),
            .nxt_stamp  (nxt_s),
            .hit_in     (hit_i),
            .valid      (valid[i]),
            .stamp      (stamp[i]),
            .hit_out    (hit[i])
        );
    end

    assign stat.head_valid = valid[0];
    assign stat.head_stamp = stamp[0];
    assign stat.full       = valid[DEPTH-1];
    assign stat.found      = hit[DEPTH-1];

endmodule

// ===== rtl/two_class_age_ordered_queue.sv =====
// The result beat appears on done in the cycle after start is taken.
// Throughput: one command per cycle; busy stays low, every start is taken.
// Each class is a row of DEPTH cells; the search is combinational and the shift is registered.
// Reset empties both queues and clears the stamp counter; stored stamps keep
// no reset value. The receiver cannot stall, so no result is ever held back.
module two_class_age_ordered_queue
    import aoq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic        kind,
    input  logic [15:0] match_stamp,
    output logic        done,
    output logic [1:0]  status,
    output logic        out_kind,
    output logic [15:0] out_stamp
);

    row_ctrl_t row_ctrl [2];
    row_stat_t row_stat [2];

    stamp_t  next_stamp_reg;
    stamp_t  next_stamp_next;
    logic    done_reg;
    status_t status_reg;
    status_t status_next;
    logic    kind_reg;
    logic    kind_next;
    field_t  stamp_reg;
    field_t  stamp_next;
    stamp_t  want;
    stamp_t  age_diff;
    logic    pick;

    for (genvar c = 0; c < 2; c++)
    begin : g_row
        aoq_row u_row (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (row_ctrl[c]),
            .stat  (row_stat[c])
        );
    end

    assign want     = field_to_stamp(match_stamp);
    assign age_diff = row_stat[1].head_stamp - row_stat[0].head_stamp;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            row_ctrl[c].op         = OP_NONE;
            row_ctrl[c].load_stamp = next_stamp_reg;
            row_ctrl[c].want       = want;
        end
        next_stamp_next = next_stamp_reg;
        status_next     = ST_OK;
        kind_next       = kind;
        stamp_next      = '0;
        pick            = 1'b0;

        if (start)
        begin
            unique case (cmd_t'(cmd))
                CMD_ENQ:
                begin
                    if (row_stat[kind].full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        row_ctrl[kind].op = OP_LOAD;
                        stamp_next        = stamp_to_field(next_stamp_reg);
                        next_stamp_next   = next_stamp_reg + stamp_t'(1);
                    end
                end
                CMD_DEQ_ANY:
                begin
                    priority if (!row_stat[0].head_valid && !row_stat[1].head_valid)
                    begin
                        status_next = ST_EMPTY;
                        kind_next   = 1'b0;
                    end
                    else
                    begin
                        priority if (!row_stat[0].head_valid)
                        begin
                            pick = 1'b1;
                        end
                        else if (!row_stat[1].head_valid)
                        begin
                            pick = 1'b0;
                        end
                        else
                        begin
                            pick = age_diff[STAMP_BITS-1];
                        end
                        row_ctrl[pick].op = OP_POP;
                        kind_next         = pick;
                        stamp_next        = stamp_to_field(row_stat[pick].head_stamp);
                    end
                end
                CMD_DEQ_CLASS:
                begin
                    if (row_stat[kind].head_valid)
                    begin
                        row_ctrl[kind].op = OP_POP;
                        stamp_next        = stamp_to_field(row_stat[kind].head_stamp);
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                CMD_REMOVE:
                begin
                    // the matching cell and all behind it shift one place
                    row_ctrl[kind].op = OP_REMOVE;
                    if (row_stat[kind].found)
                    begin
                        stamp_next = stamp_to_field(want);
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                default:
                begin
                    status_next = ST_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= 1'b0;
            next_stamp_reg <= '0;
        end
        else
        begin
            done_reg       <= start;
            next_stamp_reg <= next_stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        kind_reg   <= kind_next;
        stamp_reg  <= stamp_next;
    end

    assign busy      = 1'b0;
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_kind  = kind_reg;
    assign out_stamp = stamp_reg;

    a_done_follows_start: assert property (
        @(posedge clk) disable iff (!rst_n) start |=> done
    ) else $error("result beat missing after start");

    a_no_spurious_done: assert property (
        @(posedge clk) disable iff (!rst_n) !start |=> !done
    ) else $error("result beat without start");

    a_enq_ok: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && (cmd == CMD_ENQ) && !row_stat[kind].full)
            |=> (status == ST_OK) && (out_stamp == stamp_to_field($past(next_stamp_reg)))
    ) else $error("enqueue into non-full queue not reported ok");

    a_counter_moves_on_enq: assert property (
        @(posedge clk) disable iff (!rst_n)
        (next_stamp_reg != $past(next_stamp_reg))
            |-> $past(start && (cmd == CMD_ENQ) && !row_stat[kind].full)
    ) else $error("stamp counter advanced without a stored enqueue");

endmodule
